>>> design/zrt_pkg.sv
// Shared types and constants for the zigzag row transposer.
// Used by every module of the block but zrt_ram; depends on nothing.
package zrt_pkg;

  localparam int MAX_LEN    = 64;
  localparam int ADDR_W     = $clog2(MAX_LEN);
  localparam int LEN_W      = ADDR_W + 1;
  localparam int RAIL_W     = 7;
  localparam int BYTE_W     = 8;
  localparam int BANKS      = 2;
  localparam int RAM_DEPTH  = BANKS * MAX_LEN;
  localparam int RAM_AW     = $clog2(RAM_DEPTH);
  localparam int OQ_DEPTH   = 4;
  localparam int OQ_PTR_W   = $clog2(OQ_DEPTH);

  localparam logic [RAIL_W-1:0] RAIL_RESET = RAIL_W'(3);

  // One finished string, waiting for the back end.
  typedef struct packed {
    logic              bank;
    logic [LEN_W-1:0]  len;
    logic              ovr;
    logic [RAIL_W-1:0] rails;
  } job_t;

  // One result item as held in the output queue.
  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              last;
    logic              ovr;
  } result_t;

endpackage

>>> design/zrt_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Stand-alone; no package needed.
module zrt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> design/zrt_front.sv
// Front end: holds the rail count, loads bytes into the current bank,
// and closes a string into a job. Depends on zrt_pkg.
module zrt_front (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [zrt_pkg::RAIL_W-1:0]   cfg_data,
  input  logic                         push,
  input  logic                         jobq_full,
  input  logic [zrt_pkg::BYTE_W-1:0]   in_byte,
  input  logic                         in_last,
  output logic                         ram_we,
  output logic [zrt_pkg::RAM_AW-1:0]   ram_waddr,
  output logic [zrt_pkg::BYTE_W-1:0]   ram_wdata,
  output logic                         job_push,
  output zrt_pkg::job_t                job
);

  logic [zrt_pkg::RAIL_W-1:0] rail_count;
  logic [zrt_pkg::ADDR_W-1:0] fill;
  logic                       bank;
  logic                       accept;
  logic                       close;

  assign accept    = push && !jobq_full;
  assign close     = in_last || (fill == zrt_pkg::ADDR_W'(zrt_pkg::MAX_LEN - 1));
  assign ram_we    = accept;
  assign ram_waddr = {bank, fill};
  assign ram_wdata = in_byte;
  assign job_push  = accept && close;

  always_comb begin
    job.bank  = bank;
    job.len   = {1'b0, fill} + zrt_pkg::LEN_W'(1);
    job.ovr   = !in_last;
    job.rails = rail_count;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rail_count <= zrt_pkg::RAIL_RESET;
      fill       <= '0;
      bank       <= 1'b0;
    end else begin
      if (cfg_we) begin
        rail_count <= cfg_data;
      end
      if (accept) begin
        if (close) begin
          fill <= '0;
          bank <= !bank;
        end else begin
          fill <= fill + zrt_pkg::ADDR_W'(1);
        end
      end
    end
  end

endmodule

>>> design/zrt_job_fifo.sv
// Two-entry queue of finished strings between front and back end.
// One entry per buffer bank. Depends on zrt_pkg.
module zrt_job_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr,
  input  zrt_pkg::job_t wr_job,
  input  logic          rd,
  output logic          full,
  output logic          valid,
  output zrt_pkg::job_t head_job
);

  zrt_pkg::job_t slot [zrt_pkg::BANKS];
  logic          wptr;
  logic          rptr;
  logic [1:0]    count;

  assign full     = (count == 2'd2);
  assign valid    = (count != 2'd0);
  assign head_job = slot[rptr];

  always_ff @(posedge clk) begin
    if (wr) begin
      slot[wptr] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= '0;
    end else begin
      if (wr) begin
        wptr <= !wptr;
      end
      if (rd) begin
        rptr <= !rptr;
      end
      case ({wr, rd})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

>>> design/zrt_back.sv
// Back end: walks a bank in rail order, reads the RAM, and queues
// result items for the output side. Depends on zrt_pkg.
module zrt_back (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        job_valid,
  input  zrt_pkg::job_t               job,
  output logic                        job_pop,
  output logic [zrt_pkg::RAM_AW-1:0]  ram_raddr,
  input  logic [zrt_pkg::BYTE_W-1:0]  ram_rdata,
  input  logic                        pop,
  output logic                        empty,
  output logic [zrt_pkg::BYTE_W-1:0]  out_byte,
  output logic                        out_last,
  output logic                        overrun
);

  logic                          busy;
  logic                          bank;
  logic [zrt_pkg::LEN_W-1:0]     len;
  logic                          ovr;
  logic [zrt_pkg::RAIL_W-1:0]    rails_eff;
  logic [7:0]                    period;
  logic [zrt_pkg::RAIL_W-1:0]    rail;
  logic [7:0]                    pos;
  logic                          phase;
  logic [zrt_pkg::LEN_W-1:0]     k;

  logic                          rd_v;
  logic                          rd_last;
  logic                          rd_ovr;

  zrt_pkg::result_t              oq [zrt_pkg::OQ_DEPTH];
  logic [zrt_pkg::OQ_PTR_W-1:0]  head;
  logic [zrt_pkg::OQ_PTR_W-1:0]  tail;
  logic [zrt_pkg::OQ_PTR_W:0]    cnt;

  logic                          start;
  logic                          pass;
  logic                          issue;
  logic                          edge_rail;
  logic [7:0]                    two_r;
  logic [7:0]                    step;
  logic [8:0]                    npos;
  logic                          wrap;
  logic [zrt_pkg::RAIL_W-1:0]    rail_next;
  logic                          done;
  logic                          oq_pop;

  assign start     = job_valid && !busy;
  assign pass      = (job.rails <= zrt_pkg::RAIL_W'(1)) ||
                     ({1'b0, job.rails} >= {{(zrt_pkg::RAIL_W + 1 - zrt_pkg::LEN_W){1'b0}},
                                            job.len});
  assign issue     = busy &&
                     (({1'b0, cnt} + {{(zrt_pkg::OQ_PTR_W + 1){1'b0}}, rd_v}) <
                      (zrt_pkg::OQ_PTR_W + 2)'(zrt_pkg::OQ_DEPTH));
  assign edge_rail = (rail == '0) || (rail == rails_eff - zrt_pkg::RAIL_W'(1));
  assign two_r     = {rail, 1'b0};
  assign step      = edge_rail ? period : (phase ? two_r : (period - two_r));
  assign npos      = {1'b0, pos} + {1'b0, step};
  assign wrap      = npos >= 9'(len);
  assign rail_next = rail + zrt_pkg::RAIL_W'(1);
  assign done      = (rail_next == rails_eff);
  assign job_pop   = issue && wrap && done;
  assign ram_raddr = {bank, pos[zrt_pkg::ADDR_W-1:0]};

  // Walk state: rail, position within the bank, and the alternating step.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      rd_v <= 1'b0;
    end else begin
      rd_v <= issue;
      if (start) begin
        busy <= 1'b1;
      end else if (job_pop) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_last <= (k + zrt_pkg::LEN_W'(1)) == len;
    rd_ovr  <= ovr;
    if (start) begin
      bank      <= job.bank;
      len       <= job.len;
      ovr       <= job.ovr;
      rails_eff <= pass ? zrt_pkg::RAIL_W'(1) : job.rails;
      period    <= pass ? 8'd1 : ({job.rails, 1'b0} - 8'd2);
      rail      <= '0;
      pos       <= '0;
      phase     <= 1'b0;
      k         <= '0;
    end else if (issue) begin
      k <= k + zrt_pkg::LEN_W'(1);
      if (wrap) begin
        rail  <= rail_next;
        pos   <= 8'(rail_next);
        phase <= 1'b0;
      end else begin
        pos   <= npos[7:0];
        phase <= !phase;
      end
    end
  end

  // Output queue: room is reserved for the read in flight.
  assign oq_pop   = pop && !empty;
  assign empty    = (cnt == '0);
  assign out_byte = oq[head].data;
  assign out_last = oq[head].last;
  assign overrun  = oq[head].ovr;

  always_ff @(posedge clk) begin
    if (rd_v) begin
      oq[tail] <= '{data: ram_rdata, last: rd_last, ovr: rd_ovr};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      tail <= '0;
      cnt  <= '0;
    end else begin
      if (rd_v) begin
        tail <= tail + zrt_pkg::OQ_PTR_W'(1);
      end
      if (oq_pop) begin
        head <= head + zrt_pkg::OQ_PTR_W'(1);
      end
      case ({rd_v, oq_pop})
        2'b10:   cnt <= cnt + (zrt_pkg::OQ_PTR_W + 1)'(1);
        2'b01:   cnt <= cnt - (zrt_pkg::OQ_PTR_W + 1)'(1);
        default: cnt <= cnt;
      endcase
    end
  end

endmodule

>>> design/zigzag_row_transposer_unit.sv
// Top level of the zigzag row transposer (rail fence transposition).
// Instantiates zrt_front, zrt_job_fifo, zrt_back and zrt_ram; uses zrt_pkg.
//
//   channel   handshake            fields                     accepted when
//   input     push / full          in_byte, in_last           push && !full
//   result    empty / pop          out_byte, out_last, overrun pop && !empty
//   config    cfg_we               cfg_data (rail count)      cfg_we
//
// Each accepted input item is written straight into the buffer RAM. Once a
// string is closed, the back end registers its job, then issues reads in rail
// order; the registered RAM data enters the output queue, and the walk holds
// while that queue has no room. The single RAM read port sets the result rate.
// Reset clears counters, pointers and the rail count (back to 3); the RAM
// holds no reset. full is high while both buffer banks hold closed strings
// that the back end has not finished reading; a result stall fills the output
// queue, holds the back end's walk on its bank, and so raises full once the
// front closes a string in the other bank.
module zigzag_row_transposer_unit (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [zrt_pkg::RAIL_W-1:0]  cfg_data,
  input  logic                        push,
  output logic                        full,
  input  logic [zrt_pkg::BYTE_W-1:0]  in_byte,
  input  logic                        in_last,
  output logic                        empty,
  input  logic                        pop,
  output logic [zrt_pkg::BYTE_W-1:0]  out_byte,
  output logic                        out_last,
  output logic                        overrun
);

  // Buffer RAM: two banks of MAX_LEN bytes, selected by the top address bit.
  logic                        ram_we;
  logic [zrt_pkg::RAM_AW-1:0]  ram_waddr;
  logic [zrt_pkg::BYTE_W-1:0]  ram_wdata;
  logic [zrt_pkg::RAM_AW-1:0]  ram_raddr;
  logic [zrt_pkg::BYTE_W-1:0]  ram_rdata;

  // Job hand-off between the front and back end.
  logic                        job_push;
  zrt_pkg::job_t               job_in;
  logic                        job_valid;
  zrt_pkg::job_t               job_head;
  logic                        job_pop;

  // Load bytes and close strings; hold input while both banks are taken.
  zrt_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .push      (push),
    .jobq_full (full),
    .in_byte   (in_byte),
    .in_last   (in_last),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .job_push  (job_push),
    .job       (job_in)
  );

  // One job per bank; an entry leaves when its last read is issued.
  zrt_job_fifo u_jobq (
    .clk      (clk),
    .rst      (rst),
    .wr       (job_push),
    .wr_job   (job_in),
    .rd       (job_pop),
    .full     (full),
    .valid    (job_valid),
    .head_job (job_head)
  );

  zrt_ram #(
    .WIDTH (zrt_pkg::BYTE_W),
    .DEPTH (zrt_pkg::RAM_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Walk the rails of the oldest job and feed the result queue.
  zrt_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (job_valid),
    .job       (job_head),
    .job_pop   (job_pop),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .pop       (pop),
    .empty     (empty),
    .out_byte  (out_byte),
    .out_last  (out_last),
    .overrun   (overrun)
  );

endmodule

>>> design/zrt_checker.sv
// Port-level checks for zigzag_row_transposer_unit, attached by bind.
// Uses zrt_pkg for field widths.
module zrt_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        push,
  input logic                        full,
  input logic                        empty,
  input logic                        pop,
  input logic [zrt_pkg::BYTE_W-1:0]  out_byte,
  input logic                        out_last,
  input logic                        overrun
);

  // Reset leaves nothing pending and room for input.
  a_reset_clear: assert property (@(posedge clk) rst |=> (empty && !full))
    else $error("queue not clear after reset");

  // A waiting result holds until it is taken.
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(out_byte) && $stable(out_last) &&
                          $stable(overrun)))
    else $error("waiting result changed");

  // All results of one string carry the same overrun flag.
  a_overrun_steady: assert property (@(posedge clk) disable iff (rst)
    (!empty && pop && !out_last) |=> (empty || (overrun == $past(overrun))))
    else $error("overrun flag changed within a string");

  // Input backs up only right after an accepted item closes a string.
  a_full_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(full) |-> $past(push && !full))
    else $error("full rose without an accepted item");

endmodule

bind zigzag_row_transposer_unit zrt_checker u_zrt_checker (
  .clk      (clk),
  .rst      (rst),
  .push     (push),
  .full     (full),
  .empty    (empty),
  .pop      (pop),
  .out_byte (out_byte),
  .out_last (out_last),
  .overrun  (overrun)
);

>>> sim/zigzag_row_transposer_unit_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for zigzag_row_transposer_unit (rail fence transposition).
// Depends on zrt_pkg and the design; a scoreboard class predicts the rail order.
module zigzag_row_transposer_unit_tb;
  import zrt_pkg::*;

  // Forced opening string of a phase.
  localparam int LEAD_NONE  = 0;
  localparam int LEAD_CUT   = 1;
  localparam int LEAD_EXACT = 2;

  // Receiver stall patterns.
  localparam int unsigned MODE_STREAM   = 0;
  localparam int unsigned MODE_MOSTLY   = 1;
  localparam int unsigned MODE_PERIODIC = 2;
  localparam int unsigned MODE_RANDOM   = 3;

  // Rail order predictor with its own copy of the string buffer, fill level and
  // rail count. Closed strings turn into a queue of expected result items.
  class zigzag_scoreboard;
    logic [BYTE_W-1:0] char_buf [MAX_LEN];
    int unsigned       fill;
    logic [RAIL_W-1:0] rails;
    result_t           expected_q [$];
    int                errors;

    function new();
      fill   = 0;
      rails  = RAIL_RESET;
      errors = 0;
    endfunction

    function void set_rails(logic [RAIL_W-1:0] value);
      rails = value;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void add_expected(logic [BYTE_W-1:0] data, logic last, logic ovr);
      result_t item;
      item.data = data;
      item.last = last;
      item.ovr  = ovr;
      expected_q.push_back(item);
    endfunction

    // Note one accepted input item; on a closing byte queue the whole string.
    function void note_input(logic [BYTE_W-1:0] data, logic last);
      int unsigned len;
      int unsigned n;
      int unsigned period;
      int unsigned m;
      int unsigned k;
      logic        ovr;
      if (fill >= MAX_LEN) begin
        fill = 0;
      end
      char_buf[fill] = data;
      fill++;
      if (!last && fill < MAX_LEN) begin
        return;
      end
      len  = fill;
      ovr  = !last;
      fill = 0;
      n    = rails;
      if (n <= 1 || n >= len) begin
        for (int j = 0; j < len; j++) begin
          add_expected(char_buf[j], j + 1 == len, ovr);
        end
      end else begin
        period = 2 * n - 2;
        k = 0;
        for (int r = 0; r < n; r++) begin
          for (int j = 0; j < len; j++) begin
            m = j % period;
            if (m == r || m == period - r) begin
              add_expected(char_buf[j], k + 1 == len, ovr);
              k++;
            end
          end
        end
      end
    endfunction

    // Compare one accepted result item with the oldest expectation.
    function void check_result(logic [BYTE_W-1:0] data, logic last, logic ovr);
      result_t want;
      if (expected_q.size() == 0) begin
        $error("result item with no expectation: out_byte %0h out_last %0b overrun %0b",
               data, last, ovr);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      if (data !== want.data) begin
        $error("out_byte: expected %0h, actual %0h", want.data, data);
        errors++;
      end
      if (last !== want.last) begin
        $error("out_last: expected %0b, actual %0b", want.last, last);
        errors++;
      end
      if (ovr !== want.ovr) begin
        $error("overrun: expected %0b, actual %0b", want.ovr, ovr);
        errors++;
      end
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst;
  logic              cfg_we;
  logic [RAIL_W-1:0] cfg_data;
  logic              push;
  logic              full;
  logic [BYTE_W-1:0] in_byte;
  logic              in_last;
  logic              empty;
  logic              pop;
  logic [BYTE_W-1:0] out_byte;
  logic              out_last;
  logic              overrun;

  zigzag_scoreboard sb;

  // Sender burst state and the request for one long receiver hold-off.
  int unsigned burst_left;
  bit          hold_req;

  zigzag_row_transposer_unit uut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .push     (push),
    .full     (full),
    .in_byte  (in_byte),
    .in_last  (in_last),
    .empty    (empty),
    .pop      (pop),
    .out_byte (out_byte),
    .out_last (out_last),
    .overrun  (overrun)
  );

  // 10 ns clock: low half, then high half.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Offer one item and hold it until accepted. Every call starts and ends at a
  // rising edge. Between bursts drop push for a random gap; a zero gap skips
  // the drop so push never gets two assignments in one step.
  task automatic send_item(input logic [BYTE_W-1:0] data, input logic last);
    int  gap;
    bit  ok;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        push <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      // Now and then run a long burst with no idling at all.
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                : $urandom_range(1, 12);
    end
    push    <= 1'b1;
    in_byte <= data;
    in_last <= last;
    // Sample full in mid-cycle; the next rising edge accepts when it was low.
    do begin
      @(negedge clk);
      ok = !full;
      @(posedge clk);
    end while (!ok);
    sb.note_input(data, last);
    burst_left--;
  endtask

  // Send a string of random bytes; mark the final one last when asked.
  task automatic send_string(input int unsigned len, input bit mark_last);
    for (int i = 0; i < len; i++) begin
      send_item(8'($urandom_range(0, 255)), mark_last && (i + 1 == len));
    end
  endtask

  // Drop push, wait until every expected item has come out, then let the
  // back end settle.
  task automatic drain();
    push <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // Write the rail count; only called with the block idle.
  task automatic write_rails(input logic [RAIL_W-1:0] value);
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we   <= 1'b0;
    sb.set_rails(value);
  endtask

  // One phase: set the rail count, send the forced opening string picked by
  // lead, then short whole strings until about `budget` items have gone in.
  task automatic run_phase(input logic [RAIL_W-1:0] rails_value, input int unsigned budget,
                           input int lead, input bit hold);
    int unsigned sent;
    int unsigned len;
    write_rails(rails_value);
    hold_req = hold;
    sent = 0;
    if (lead == LEAD_CUT) begin
      send_string(MAX_LEN, 1'b0);
      sent += MAX_LEN;
    end else if (lead == LEAD_EXACT) begin
      send_string(MAX_LEN, 1'b1);
      sent += MAX_LEN;
    end
    while (sent < budget) begin
      len = $urandom_range(1, 24);
      send_string(len, 1'b1);
      sent += len;
    end
    drain();
  endtask

  // Receiver: sample empty and the result fields in mid-cycle, check at the
  // edge that accepts the item, then pick pop for the next cycle. The stall
  // pattern switches at random among several modes; a hold-off request parks pop low
  // for a long stretch so the block fills and pushes back on the sender.
  initial begin
    bit                take;
    logic [BYTE_W-1:0] got_byte;
    logic              got_last;
    logic              got_ovr;
    int unsigned       cyc;
    int unsigned       hold_cnt;
    int unsigned       mode;
    pop      <= 1'b0;
    cyc      = 0;
    hold_cnt = 0;
    mode     = MODE_STREAM;
    forever begin
      @(negedge clk);
      take = pop && !empty;
      if (take) begin
        got_byte = out_byte;
        got_last = out_last;
        got_ovr  = overrun;
      end
      @(posedge clk);
      if (take) begin
        sb.check_result(got_byte, got_last, got_ovr);
      end
      cyc++;
      if (cyc % 64 == 0) begin
        mode = $urandom_range(MODE_STREAM, MODE_RANDOM);
      end
      if (hold_req && hold_cnt == 0) begin
        hold_cnt = 400;
      end
      if (hold_cnt > 0) begin
        pop <= 1'b0;
        hold_cnt--;
        if (hold_cnt == 0) begin
          hold_req = 1'b0;
        end
      end else begin
        case (mode)
          MODE_STREAM: begin
            pop <= 1'b1;
          end
          MODE_MOSTLY: begin
            pop <= ($urandom_range(0, 3) != 0);
          end
          MODE_PERIODIC: begin
            pop <= (cyc % 5 != 0);
          end
          default: begin
            pop <= 1'($urandom_range(0, 1));
          end
        endcase
      end
    end
  end

  // Main stimulus: directed strings first, then the random phases.
  initial begin
    string msg;
    sb         = new();
    burst_left = 0;
    hold_req   = 1'b0;
    rst      <= 1'b1;
    cfg_we   <= 1'b0;
    cfg_data <= '0;
    push     <= 1'b0;
    in_byte  <= '0;
    in_last  <= 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    repeat (4) @(posedge clk);

    // Reset rail count (three rails): classic textbook string.
    msg = "WEAREDISCOVERED";
    for (int i = 0; i < msg.len(); i++) begin
      send_item(msg[i], i + 1 == msg.len());
    end
    // Single byte at the top of the range, then a string shorter than the
    // rail count, which passes unchanged.
    send_item(8'hFF, 1'b1);
    send_item(8'h00, 1'b0);
    send_item(8'h80, 1'b1);
    drain();

    // Zero rails acts as one rail.
    write_rails(RAIL_W'(0));
    send_item(8'h01, 1'b0);
    send_item(8'h7F, 1'b0);
    send_item(8'hFE, 1'b1);
    drain();

    // Two rails: even positions, then odd positions.
    write_rails(RAIL_W'(2));
    send_item(8'hA5, 1'b0);
    send_item(8'h5A, 1'b0);
    send_item(8'hC3, 1'b0);
    send_item(8'h3C, 1'b1);
    drain();

    // A string exactly at capacity with as many rails as bytes. Then the long
    // receiver hold-off: a string cut at capacity, a short string that takes
    // the second bank, and at least one more string offered while full is
    // high. Last, rail counts above the range and exactly one rail.
    run_phase(RAIL_W'(64), MAX_LEN, LEAD_EXACT, 1'b0);
    run_phase(RAIL_W'($urandom_range(2, 40)), MAX_LEN + 25, LEAD_CUT, 1'b1);
    run_phase(RAIL_W'(127), 1, LEAD_NONE, 1'b0);
    run_phase(RAIL_W'(1), 1, LEAD_NONE, 1'b0);

    // drain() has already waited for the queue and the trailing cycles.
    if (sb.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #2000000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
